// ===== design/i2cswr_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C slave write receiver package
// Shared widths, the reset address constant and the result transaction type.
// ----------------------------------------------------------------------------
package i2cswr_pkg;

  localparam int unsigned ADDR_W = 7;
  localparam int unsigned BYTE_W = 8;

  localparam logic [ADDR_W-1:0] OWN_ADDR_RESET = 7'h50;

  // One result transaction.
  typedef struct packed {
    logic              sda_pull_low;
    logic              data_strobe;
    logic [BYTE_W-1:0] latched_byte;
  } res_t;

endpackage

// ===== design/i2cswr_fsm.sv =====
// ----------------------------------------------------------------------------
// I2C slave write receiver protocol engine
// Holds the line history and transfer state; advances once per accepted sample.
// ----------------------------------------------------------------------------
module i2cswr_fsm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic                               scl_level,
  input  logic                               sda_level,
  input  logic [i2cswr_pkg::ADDR_W-1:0]      own_address,
  output i2cswr_pkg::res_t                   res
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_ADDR     = 3'd1;
  localparam logic [2:0] PH_ACK_ADDR = 3'd2;
  localparam logic [2:0] PH_DATA     = 3'd3;
  localparam logic [2:0] PH_ACK_DATA = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  logic                               prev_clock_r, prev_clock_nxt;
  logic                               prev_data_r,  prev_data_nxt;
  logic [2:0]                         phase_r,      phase_nxt;
  logic [3:0]                         bit_count_r,  bit_count_nxt;
  logic [i2cswr_pkg::BYTE_W-1:0]      shift_r,      shift_nxt;
  logic                               ack_r,        ack_nxt;
  logic [i2cswr_pkg::BYTE_W-1:0]      held_r,       held_nxt;
  logic                               strobe;
  logic                               rise, fall, start;
  logic                               addr_hit;

  assign rise  = !prev_clock_r && scl_level;
  assign fall  = prev_clock_r && !scl_level;
  assign start = prev_clock_r && scl_level && prev_data_r && !sda_level;
  assign addr_hit = (shift_r[i2cswr_pkg::BYTE_W-1:1] == own_address) && !shift_r[0];

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    ack_nxt       = ack_r;
    held_nxt      = held_r;
    strobe        = 1'b0;
    prev_clock_nxt = scl_level;
    prev_data_nxt  = sda_level;

    if (start) begin
      // A start in any phase abandons the current transfer.
      phase_nxt     = PH_ADDR;
      bit_count_nxt = '0;
      shift_nxt     = '0;
      ack_nxt       = 1'b0;
    end else if (phase_r inside {PH_ADDR, PH_DATA}) begin
      if (rise && (bit_count_r < BITS_PER_BYTE)) begin
        shift_nxt     = {shift_r[i2cswr_pkg::BYTE_W-2:0], sda_level};
        bit_count_nxt = bit_count_r + 4'd1;
      end else if (fall && (bit_count_r >= BITS_PER_BYTE)) begin
        ack_nxt   = 1'b1;
        phase_nxt = (phase_r == PH_ADDR) ? PH_ACK_ADDR : PH_ACK_DATA;
      end
    end else begin
      case (phase_r)
        PH_ACK_ADDR: begin
          if (fall) begin
            ack_nxt       = 1'b0;
            bit_count_nxt = '0;
            if (addr_hit) begin
              phase_nxt = PH_DATA;
              shift_nxt = '0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_ACK_DATA: begin
          if (fall) begin
            ack_nxt       = 1'b0;
            held_nxt      = shift_r;
            strobe        = 1'b1;
            phase_nxt     = PH_IDLE;
            bit_count_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_clock_r <= 1'b1;
      prev_data_r  <= 1'b1;
      phase_r      <= PH_IDLE;
      bit_count_r  <= '0;
      shift_r      <= '0;
      ack_r        <= 1'b0;
      held_r       <= '0;
    end else if (step) begin
      prev_clock_r <= prev_clock_nxt;
      prev_data_r  <= prev_data_nxt;
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      ack_r        <= ack_nxt;
      held_r       <= held_nxt;
    end
  end

  assign res.sda_pull_low = ack_nxt;
  assign res.data_strobe  = strobe;
  assign res.latched_byte = held_nxt;

endmodule

// ===== design/i2cswr_outbuf.sv =====
// ----------------------------------------------------------------------------
// I2C slave write receiver output buffer
// Result register with one skid entry, so a stalled receiver costs no sample.
// ----------------------------------------------------------------------------
module i2cswr_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cswr_pkg::res_t  push_res,
  input  logic              out_stall,
  output logic              out_valid,
  output i2cswr_pkg::res_t  out_res,
  output logic              full
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  i2cswr_pkg::res_t out_res_r, skid_res_r;
  logic             pop;
  logic             load_out, load_skid;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        // Skid entry is older; push cannot happen while it is occupied.
        load_out       = 1'b1;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        load_out      = push;
        out_valid_nxt = push;
      end
    end else if (push) begin
      load_skid      = 1'b1;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= skid_valid_r ? skid_res_r : push_res;
    end
    if (load_skid) begin
      skid_res_r <= push_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign full      = skid_valid_r;

endmodule

// ===== design/i2c_slave_write_receiver.sv =====
// ----------------------------------------------------------------------------
// I2C slave write receiver
// Seven-bit address I2C target that accepts a single-byte write.
// ----------------------------------------------------------------------------
// The input channel carries one sample of the SCL and SDA lines per
// transaction; samples are normally offered every system clock so that bus
// edges are seen against the previous sample. Each accepted sample produces
// exactly one result transaction: the acknowledge drive for SDA, a one-shot
// data strobe and the last received data byte.
// Each result is registered in the output buffer. Throughput is one sample
// per cycle while in_stall is low, set by the protocol engine that updates
// its state on every sample. When the result side stalls, one further sample
// is held in a skid entry and in_stall then rises until the output drains, so
// nothing is lost or repeated. At reset the bus history reads as idle high,
// the engine waits for a start condition, SDA is released, the held byte is
// zero and the own address is 0x50. The address is changed through cfg_wr_en
// and cfg_wr_data, by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module i2c_slave_write_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [i2cswr_pkg::ADDR_W-1:0]     cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_scl_level,
  input  logic                              in_sda_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_sda_pull_low,
  output logic                              out_data_strobe,
  output logic [i2cswr_pkg::BYTE_W-1:0]     out_latched_byte
);

  logic [i2cswr_pkg::ADDR_W-1:0] own_address_r;
  logic                          accept;
  logic                          buf_full;
  i2cswr_pkg::res_t              step_res;
  i2cswr_pkg::res_t              out_res;

  // Configuration register: written directly, no handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= i2cswr_pkg::OWN_ADDR_RESET;
    end else if (cfg_wr_en) begin
      own_address_r <= cfg_wr_data;
    end
  end

  // A sample transaction is taken whenever the skid entry is free.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  i2cswr_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .scl_level   (in_scl_level),
    .sda_level   (in_sda_level),
    .own_address (own_address_r),
    .res         (step_res)
  );

  i2cswr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  assign out_sda_pull_low = out_res.sda_pull_low;
  assign out_data_strobe  = out_res.data_strobe;
  assign out_latched_byte = out_res.latched_byte;

endmodule

// ===== tb/sv/tb_i2c_slave_write_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C slave write receiver testbench
// Plays the role of a bus master that writes single bytes over sampled
// SCL/SDA lines. Every sample is predicted by a cycle model of the receiver,
// and every result transaction is compared field by field with the model.
// ----------------------------------------------------------------------------
module tb_i2c_slave_write_receiver;

  // A run ends early if no transaction is taken on either side for this long.
  localparam int unsigned QUIET_LIMIT = 1000;
  // Cycles allowed for the output register to settle after the last result.
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef logic [i2cswr_pkg::ADDR_W-1:0] addr_t;
  typedef logic [i2cswr_pkg::BYTE_W-1:0] byte_t;

  // Receiver protocol phases as the model tracks them.
  typedef enum logic [2:0] {
    RX_IDLE,
    RX_ADDR,
    RX_ACK_ADDR,
    RX_DATA,
    RX_ACK_DATA
  } rx_phase_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  addr_t             cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_scl_level;
  logic              in_sda_level;
  logic              out_valid;
  logic              out_stall;
  logic              out_sda_pull_low;
  logic              out_data_strobe;
  byte_t             out_latched_byte;

  // Model state. The line levels double as the bus state that the stimulus
  // builds its next edge from, since both are simply the last accepted sample.
  logic              line_scl;
  logic              line_sda;
  rx_phase_t         rx_phase;
  logic [3:0]        rx_bits;
  byte_t             rx_shift;
  logic              rx_ack;
  byte_t             rx_held;
  addr_t             rx_own_addr;

  i2cswr_pkg::res_t pending_results[$];
  int unsigned      fail_count;
  int unsigned      samples_sent;
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;
  int unsigned      hold_max;

  i2c_slave_write_receiver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_scl_level     (in_scl_level),
    .in_sda_level     (in_sda_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sda_pull_low (out_sda_pull_low),
    .out_data_strobe  (out_data_strobe),
    .out_latched_byte (out_latched_byte)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver model
  // --------------------------------------------------------------------------

  task automatic reset_model();
    line_scl    = 1'b1;
    line_sda    = 1'b1;
    rx_phase    = RX_IDLE;
    rx_bits     = '0;
    rx_shift    = '0;
    rx_ack      = 1'b0;
    rx_held     = '0;
    rx_own_addr = i2cswr_pkg::OWN_ADDR_RESET;
  endtask

  // Advances the model by one bus sample and returns the result it implies.
  // Edges are judged against the previous sample; a start condition (SDA
  // falling while SCL stays high) wins over anything else in any phase.
  function automatic i2cswr_pkg::res_t predict_sample(input logic scl, input logic sda);
    logic rise;
    logic fall;
    logic start;
    i2cswr_pkg::res_t r;
    rise  = !line_scl && scl;
    fall  = line_scl && !scl;
    start = line_scl && scl && line_sda && !sda;
    r.data_strobe = 1'b0;
    if (start) begin
      rx_phase = RX_ADDR;
      rx_bits  = '0;
      rx_shift = '0;
      rx_ack   = 1'b0;
    end else begin
      case (rx_phase)
        RX_ADDR, RX_DATA: begin
          if (rise && rx_bits < 8) begin
            rx_shift = {rx_shift[i2cswr_pkg::BYTE_W-2:0], sda};
            rx_bits  = rx_bits + 1'b1;
          end else if (fall && rx_bits >= 8) begin
            // The acknowledge drive starts on the fall after the eighth bit.
            rx_ack   = 1'b1;
            rx_phase = (rx_phase == RX_ADDR) ? RX_ACK_ADDR : RX_ACK_DATA;
          end
        end
        RX_ACK_ADDR: begin
          if (fall) begin
            rx_ack  = 1'b0;
            rx_bits = '0;
            // Only a write to our own address goes on to a data byte.
            if (rx_shift[i2cswr_pkg::BYTE_W-1:1] == rx_own_addr && !rx_shift[0]) begin
              rx_phase = RX_DATA;
              rx_shift = '0;
            end else begin
              rx_phase = RX_IDLE;
            end
          end
        end
        RX_ACK_DATA: begin
          if (fall) begin
            rx_ack        = 1'b0;
            rx_held       = rx_shift;
            r.data_strobe = 1'b1;
            rx_phase      = RX_IDLE;
            rx_bits       = '0;
          end
        end
        default: rx_phase = RX_IDLE;
      endcase
    end
    line_scl = scl;
    line_sda = sda;
    r.sda_pull_low = rx_ack;
    r.latched_byte = rx_held;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver and bus-level sequences
  // --------------------------------------------------------------------------

  // Offers one sample, idling beforehand at the current rate, and holds it
  // until it is taken. The expectation is queued at the accepting edge.
  task automatic send_sample(input logic scl, input logic sda);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_scl_level <= scl;
    in_sda_level <= sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_sample(scl, sda));
    samples_sent++;
  endtask

  // One SCL period with SDA set up while the clock is low. Each level lasts
  // between one and hold_max samples.
  task automatic clock_bit(input logic b);
    repeat ($urandom_range(1, hold_max)) send_sample(1'b0, b);
    repeat ($urandom_range(1, hold_max)) send_sample(1'b1, b);
  endtask

  // Brings both lines high if needed, then drops SDA with SCL high.
  task automatic start_cond();
    if (!(line_scl && line_sda)) begin
      if (line_scl) send_sample(1'b0, line_sda);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
    end
    send_sample(1'b1, 1'b0);
  endtask

  task automatic stop_cond();
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
  endtask

  // Eight bits MSB first, then the acknowledge bit with the line held low as the
  // receiver's acknowledge would leave it.
  task automatic send_byte(input byte_t value);
    for (int i = i2cswr_pkg::BYTE_W - 1; i >= 0; i--) clock_bit(value[i]);
    clock_bit(1'b0);
  endtask

  // Address byte and one data byte. The data byte is always clocked out;
  // when the address is not ours the receiver should simply ignore it.
  // Half of the transfers end in a stop, the rest run into a repeated start.
  task automatic bus_write(input addr_t addr, input logic rw, input byte_t value);
    start_cond();
    send_byte({addr, rw});
    send_byte(value);
    if ($urandom_range(1)) stop_cond();
  endtask

  // Data bytes lean towards the all-zeros and all-ones extremes.
  function automatic byte_t pick_byte();
    int unsigned p;
    p = $urandom_range(9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return byte_t'($urandom_range(255));
  endfunction

  // Lowers valid, waits until every queued result has been taken and lets
  // the output register settle before the address register is touched.
  task automatic set_own_address(input addr_t addr);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rx_own_addr = addr;
  endtask

  // Mostly well-formed writes to our own address with random data, mixed
  // with reads, foreign addresses, transfers cut short by a new start and
  // plain line noise.
  task automatic run_bus_traffic(input int unsigned n_samples);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = samples_sent + n_samples;
    while (samples_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        bus_write(rx_own_addr, 1'b0, pick_byte());
      end else if (pick < 70) begin
        bus_write(rx_own_addr, 1'b1, pick_byte());
      end else if (pick < 80) begin
        bus_write(addr_t'($urandom_range(127)), 1'($urandom_range(1)), pick_byte());
      end else if (pick < 90) begin
        start_cond();
        repeat ($urandom_range(1, 17)) clock_bit(1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 12))
          send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // SCL toggling with SDA moving only while SCL is low: no start is formed,
  // so the receiver must stay idle and keep SDA released.
  task automatic test_idle_bus_activity();
    tx_idle_pct = 19;
    rx_idle_pct = 78;
    hold_max    = 1;
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
  endtask

  // An address byte abandoned after three bits by a repeated start, then a
  // complete all-ones write to the reset address at the shortest clock.
  task automatic test_restart_during_address();
    start_cond();
    repeat (3) clock_bit(1'b1);
    bus_write(rx_own_addr, 1'b0, 8'hFF);
    stop_cond();
  endtask

  // Sender idles lightly and the receiver stalls heavily, with the address
  // register at its lowest and then its highest value.
  task automatic test_address_extremes();
    tx_idle_pct = 19;
    rx_idle_pct = 78;
    hold_max    = 2;
    set_own_address('0);
    run_bus_traffic(275);
    set_own_address('1);
    run_bus_traffic(275);
  endtask

  // The other way round: a sparse sender and a mostly willing receiver.
  task automatic test_random_address();
    tx_idle_pct = 78;
    rx_idle_pct = 19;
    set_own_address(addr_t'($urandom_range(127)));
    run_bus_traffic(550);
  endtask

  // Back-to-back samples and no stalls, back at the reset address.
  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_own_address(i2cswr_pkg::OWN_ADDR_RESET);
    run_bus_traffic(550);
  endtask

  // --------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Each result transaction taken is checked against the oldest expectation.
  always @(posedge clk) begin : check_result
    i2cswr_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no sample outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_sda_pull_low !== want.sda_pull_low) begin
          $error("sda_pull_low: expected %0d, got %0d", want.sda_pull_low, out_sda_pull_low);
          fail_count++;
        end
        if (out_data_strobe !== want.data_strobe) begin
          $error("data_strobe: expected %0d, got %0d", want.data_strobe, out_data_strobe);
          fail_count++;
        end
        if (out_latched_byte !== want.latched_byte) begin
          $error("latched_byte: expected 0x%02h, got 0x%02h",
                 want.latched_byte, out_latched_byte);
          fail_count++;
        end
      end
    end
  end

  // Counts consecutive cycles in which neither side completes a transaction.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL i2c_slave_write_receiver");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin : run_tests
    // Every driven input is at a known value before the first clock edge; the
    // bus lines start high, as an idle bus would read. The result stall is
    // set at the first edge, while reset is still held.
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= i2cswr_pkg::OWN_ADDR_RESET;
    in_valid     <= 1'b0;
    in_scl_level <= 1'b1;
    in_sda_level <= 1'b1;
    fail_count   = 0;
    samples_sent = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_max     = 1;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_bus_activity();
    test_restart_during_address();
    test_address_extremes();
    test_random_address();
    test_full_rate();

    // Stop offering samples, collect the remaining results and give the
    // output one last chance to show anything unexpected.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS i2c_slave_write_receiver");
    end else begin
      $display("FAIL i2c_slave_write_receiver");
    end
    $finish;
  end

endmodule
